// ===== sv/hrhp_pkg.sv =====
//------------------------------------------------------------------------------
// hrhp_pkg
// Shared types, constants and character functions of the HTTP request header parser.
//------------------------------------------------------------------------------
`default_nettype none
package hrhp_pkg;

  localparam int unsigned PathBytes = 256;
  localparam int unsigned HostBytes = 256;
  localparam int unsigned ConnBytes = 64;

  localparam logic [1:0] CLS_OTHER = 2'd0;
  localparam logic [1:0] CLS_PATH  = 2'd1;
  localparam logic [1:0] CLS_HOST  = 2'd2;
  localparam logic [1:0] CLS_CONN  = 2'd3;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_COMMIT  = 2'd1;
  localparam logic [1:0] ACT_DISCARD = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3a;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] byte_class;
    logic [1:0] value_action;
    logic       done_res;
    logic       parse_error;
    logic [2:0] method_code;
    logic       version_minor;
    logic       conn_persist;
    logic [7:0] path_length;
    logic [7:0] host_length;
    logic [5:0] connection_length;
  } out_item_t;

  // Method text, character p of method m; 0 beyond its length, for p below 7.
  function automatic logic [7:0] meth_char(input logic [2:0] m, input logic [2:0] p);
    logic [55:0] s;
    unique case (m)
      3'd0:    s = {"GET", 32'h0};
      3'd1:    s = {"POST", 24'h0};
      3'd2:    s = {"PUT", 32'h0};
      3'd3:    s = {"DELETE", 8'h0};
      default: s = "OPTIONS";
    endcase
    return s[6'(55 - 8 * int'(p)) -: 8];
  endfunction

  function automatic logic [3:0] meth_len(input logic [2:0] m);
    unique case (m)
      3'd0:    return 4'd3;
      3'd1:    return 4'd4;
      3'd2:    return 4'd3;
      3'd3:    return 4'd6;
      default: return 4'd7;
    endcase
  endfunction

  function automatic logic [7:0] ver_char(input logic [2:0] p);
    logic [55:0] s;
    s = "HTTP/1.";
    return s[6'(55 - 8 * int'(p)) -: 8];
  endfunction

  function automatic logic [7:0] host_char(input logic [1:0] p);
    logic [31:0] s;
    s = "host";
    return s[5'(31 - 8 * int'(p)) -: 8];
  endfunction

  function automatic logic [7:0] conn_char(input logic [3:0] p);
    logic [79:0] s;
    s = "connection";
    return s[7'(79 - 8 * int'(p)) -: 8];
  endfunction

  function automatic logic [7:0] ka_char(input logic [3:0] p);
    logic [79:0] s;
    s = "keep-alive";
    return s[7'(79 - 8 * int'(p)) -: 8];
  endfunction

  function automatic logic [7:0] close_char(input logic [2:0] p);
    logic [39:0] s;
    s = "close";
    return s[6'(39 - 8 * int'(p)) -: 8];
  endfunction

  function automatic logic [7:0] lower_byte(input logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

endpackage
`default_nettype wire

// ===== sv/hrhp_stream_if.sv =====
//------------------------------------------------------------------------------
// hrhp_stream_if
// Valid/ready channel carrying one payload item per request.
//------------------------------------------------------------------------------
`default_nettype none
interface hrhp_in_if;
  logic               valid;
  logic               ready;
  hrhp_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hrhp_out_if;
  logic                valid;
  logic                ready;
  hrhp_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/http_request_header_parser_unit.sv =====
//------------------------------------------------------------------------------
// http_request_header_parser_unit
// Byte-serial HTTP/1.x request line and Host/Connection header parser.
//------------------------------------------------------------------------------
// Channel  Dir  Payload
// in_      in   data_byte, frame_start, frame_end
// out_     out  out_byte, class, action, done, error, method, version, lengths
//
// One byte per cycle while the output is read: every accepted request gives one result in the next
// cycle, computed by one pass of logic from the parser state registers.
// A result waits in the output register; a new request is taken whenever
// that register is empty or being read in the same cycle.
// Reset (rst_n low, synchronous) returns the parser to the method phase.
//------------------------------------------------------------------------------
`default_nettype none
module http_request_header_parser_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hrhp_in_if.sink    in_ch,
  hrhp_out_if.source out_ch
);

  typedef enum logic [3:0] {
    PH_METHOD = 4'd0, PH_PATH = 4'd1, PH_VERSION = 4'd2, PH_LINE_REST = 4'd3,
    PH_NAME = 4'd4, PH_VALUE_LEAD = 4'd5, PH_VALUE = 4'd6, PH_DONE = 4'd8
  } phase_t;

  localparam logic [15:0] CntCap = 16'hffff;
  localparam logic [8:0]  PosCap = 9'h1ff;

  phase_t      phase_r, phase_nxt;
  logic [8:0]  pos_r, pos_nxt;
  logic [4:0]  cand_r, cand_nxt;
  logic [15:0] path_cnt_r, path_cnt_nxt;
  logic        ver_r, ver_nxt;
  logic [1:0]  hflags_r, hflags_nxt;
  logic [15:0] vcnt_r, vcnt_nxt;
  logic        cr_r, cr_nxt;
  logic        err_r, err_nxt;
  logic [15:0] host_len_r, host_len_nxt;
  logic [15:0] conn_len_r, conn_len_nxt;
  logic [1:0]  cmatch_r, cmatch_nxt;
  logic [1:0]  pmatch_r, pmatch_nxt;
  logic        out_valid_r;
  hrhp_pkg::out_item_t out_r, res_nxt;

  logic accept;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_comb begin
    logic [7:0]  b, lb;
    logic        st, en, crb, found;
    logic [4:0]  nx;
    logic [2:0]  p3;
    logic [15:0] len;
    logic [1:0]  cls, act, tgt;
    logic [2:0]  code;
    b  = in_ch.data.data_byte;
    st = in_ch.data.frame_start;
    en = in_ch.data.frame_end;
    lb = hrhp_pkg::lower_byte(b);
    phase_nxt = st ? PH_METHOD : phase_r;
    pos_nxt = st ? '0 : pos_r;
    cand_nxt = st ? 5'h1f : cand_r;
    path_cnt_nxt = st ? '0 : path_cnt_r;
    ver_nxt = st ? 1'b0 : ver_r;
    hflags_nxt = st ? '0 : hflags_r;
    vcnt_nxt = st ? '0 : vcnt_r;
    cr_nxt = st ? 1'b0 : cr_r;
    err_nxt = st ? 1'b0 : err_r;
    host_len_nxt = st ? '0 : host_len_r;
    conn_len_nxt = st ? '0 : conn_len_r;
    cmatch_nxt = st ? '0 : cmatch_r;
    pmatch_nxt = st ? '0 : pmatch_r;
    crb = cr_nxt;
    cls = hrhp_pkg::CLS_OTHER;
    act = hrhp_pkg::ACT_NONE;
    found = 1'b0;
    nx = '0;
    p3 = '0;
    len = '0;
    tgt = hflags_nxt;
    code = '0;

    unique case (phase_nxt)
      PH_METHOD: begin
        // The lowest candidate that is complete and sees a space wins.
        for (int i = 4; i >= 0; i--) begin
          if (cand_nxt[i]) begin
            if ({5'd0, hrhp_pkg::meth_len(3'(i))} == pos_nxt && b == hrhp_pkg::CH_SP) begin
              found = 1'b1;
              nx = 5'(1 << i);
            end
          end
        end
        if (!found) begin
          nx = '0;
          for (int i = 0; i < 5; i++) begin
            if (cand_nxt[i] && pos_nxt < {5'd0, hrhp_pkg::meth_len(3'(i))} &&
                b == hrhp_pkg::meth_char(3'(i), pos_nxt[2:0]))
              nx[i] = 1'b1;
          end
        end
        if (found) begin
          cand_nxt = nx;
          phase_nxt = PH_PATH;
          pos_nxt = '0;
        end else begin
          cand_nxt = nx;
          if (nx == '0) begin
            phase_nxt = PH_DONE;
            err_nxt = 1'b1;
          end else begin
            pos_nxt = pos_nxt + 9'd1;
          end
        end
      end
      PH_PATH: begin
        if (b == hrhp_pkg::CH_SP) begin
          if (path_cnt_nxt >= 16'(hrhp_pkg::PathBytes)) begin
            phase_nxt = PH_DONE;
            err_nxt = 1'b1;
          end else begin
            phase_nxt = PH_VERSION;
            pos_nxt = '0;
          end
        end else if (b == hrhp_pkg::CH_CR || b == hrhp_pkg::CH_LF) begin
          phase_nxt = PH_DONE;
          err_nxt = 1'b1;
        end else begin
          cls = hrhp_pkg::CLS_PATH;
          if (path_cnt_nxt < CntCap) path_cnt_nxt = path_cnt_nxt + 16'd1;
        end
      end
      PH_VERSION: begin
        p3 = pos_nxt[2:0];
        if (p3 != 3'd7) begin
          if (b != hrhp_pkg::ver_char(p3)) begin
            phase_nxt = PH_DONE;
            err_nxt = 1'b1;
          end else begin
            pos_nxt = {6'd0, p3 + 3'd1};
          end
        end else if (b == "0" || b == "1") begin
          ver_nxt = b[0];
          phase_nxt = PH_LINE_REST;
        end else begin
          phase_nxt = PH_DONE;
          err_nxt = 1'b1;
        end
      end
      PH_LINE_REST: begin
        if (b == hrhp_pkg::CH_LF) begin
          phase_nxt = PH_NAME;
          pos_nxt = '0;
          hflags_nxt = 2'd3;
          vcnt_nxt = '0;
        end
      end
      PH_NAME: begin
        if (b == hrhp_pkg::CH_LF) begin
          if (pos_nxt == 9'd0 || (pos_nxt == 9'd1 && crb)) begin
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_NAME;
            pos_nxt = '0;
            hflags_nxt = 2'd3;
            vcnt_nxt = '0;
          end
        end else if (b == hrhp_pkg::CH_COLON) begin
          if (pos_nxt == 9'd4 && hflags_nxt[0]) tgt = 2'd1;
          else if (pos_nxt == 9'd10 && hflags_nxt[1]) tgt = 2'd2;
          else tgt = 2'd0;
          hflags_nxt = tgt;
          phase_nxt = PH_VALUE_LEAD;
          vcnt_nxt = '0;
          pmatch_nxt = 2'd3;
        end else begin
          if (!(pos_nxt < 9'd4 && lb == hrhp_pkg::host_char(pos_nxt[1:0])))
            hflags_nxt[0] = 1'b0;
          if (!(pos_nxt < 9'd10 && lb == hrhp_pkg::conn_char(pos_nxt[3:0])))
            hflags_nxt[1] = 1'b0;
          if (pos_nxt < PosCap) pos_nxt = pos_nxt + 9'd1;
        end
      end
      PH_VALUE_LEAD, PH_VALUE: begin
        if (!(phase_nxt == PH_VALUE_LEAD && (b == hrhp_pkg::CH_SP || b == hrhp_pkg::CH_TAB)))
        begin
          tgt = hflags_nxt;
          phase_nxt = PH_VALUE;
          if (b == hrhp_pkg::CH_LF) begin
            len = vcnt_nxt;
            if (crb && len != '0) len = len - 16'd1;
            if (tgt == 2'd1) begin
              if (len < 16'(hrhp_pkg::HostBytes)) begin
                host_len_nxt = len;
                act = hrhp_pkg::ACT_COMMIT;
              end else act = hrhp_pkg::ACT_DISCARD;
            end else if (tgt == 2'd2) begin
              if (len < 16'(hrhp_pkg::ConnBytes)) begin
                conn_len_nxt = len;
                cmatch_nxt = {pmatch_nxt[1] && len == 16'd5, pmatch_nxt[0] && len == 16'd10};
                act = hrhp_pkg::ACT_COMMIT;
              end else act = hrhp_pkg::ACT_DISCARD;
            end
            phase_nxt = PH_NAME;
            pos_nxt = '0;
            hflags_nxt = 2'd3;
            vcnt_nxt = '0;
          end else begin
            cls = (tgt == 2'd1) ? hrhp_pkg::CLS_HOST :
                  (tgt == 2'd2) ? hrhp_pkg::CLS_CONN : hrhp_pkg::CLS_OTHER;
            if (tgt == 2'd2) begin
              if (crb) pmatch_nxt = '0;
              if (b != hrhp_pkg::CH_CR) begin
                if (!(vcnt_nxt < 16'd10 && lb == hrhp_pkg::ka_char(vcnt_nxt[3:0])))
                  pmatch_nxt[0] = 1'b0;
                if (!(vcnt_nxt < 16'd5 && lb == hrhp_pkg::close_char(vcnt_nxt[2:0])))
                  pmatch_nxt[1] = 1'b0;
              end
            end
            if (vcnt_nxt < CntCap) vcnt_nxt = vcnt_nxt + 16'd1;
          end
        end
      end
      default: begin
      end
    endcase

    if (phase_nxt != PH_DONE) cr_nxt = (b == hrhp_pkg::CH_CR);

    if (en && phase_nxt != PH_DONE) begin
      if (phase_nxt <= PH_LINE_REST) err_nxt = 1'b1;
      else if ((phase_nxt == PH_VALUE_LEAD || phase_nxt == PH_VALUE) && hflags_nxt != 2'd0)
        act = hrhp_pkg::ACT_DISCARD;
      phase_nxt = PH_DONE;
    end

    priority if (cand_nxt[0]) code = 3'd0;
    else if (cand_nxt[1]) code = 3'd1;
    else if (cand_nxt[2]) code = 3'd2;
    else if (cand_nxt[3]) code = 3'd3;
    else if (cand_nxt[4]) code = 3'd4;
    else code = 3'd0;

    res_nxt.out_byte = b;
    res_nxt.byte_class = cls;
    res_nxt.value_action = act;
    res_nxt.done_res = (phase_nxt == PH_DONE);
    res_nxt.parse_error = err_nxt;
    res_nxt.method_code = code;
    res_nxt.version_minor = ver_nxt;
    res_nxt.conn_persist = ver_nxt ? !cmatch_nxt[1] : cmatch_nxt[0];
    res_nxt.path_length = (path_cnt_nxt > 16'd255) ? 8'd255 : path_cnt_nxt[7:0];
    res_nxt.host_length = (host_len_nxt > 16'd255) ? 8'd255 : host_len_nxt[7:0];
    res_nxt.connection_length = (conn_len_nxt > 16'd63) ? 6'd63 : conn_len_nxt[5:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_METHOD;
      pos_r <= '0;
      cand_r <= 5'h1f;
      path_cnt_r <= '0;
      ver_r <= 1'b0;
      hflags_r <= '0;
      vcnt_r <= '0;
      cr_r <= 1'b0;
      err_r <= 1'b0;
      host_len_r <= '0;
      conn_len_r <= '0;
      cmatch_r <= '0;
      pmatch_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        pos_r <= pos_nxt;
        cand_r <= cand_nxt;
        path_cnt_r <= path_cnt_nxt;
        ver_r <= ver_nxt;
        hflags_r <= hflags_nxt;
        vcnt_r <= vcnt_nxt;
        cr_r <= cr_nxt;
        err_r <= err_nxt;
        host_len_r <= host_len_nxt;
        conn_len_r <= conn_len_nxt;
        cmatch_r <= cmatch_nxt;
        pmatch_r <= pmatch_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_r <= res_nxt;
  end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
//------------------------------------------------------------------------------
// tb
// Self-checking bench for the HTTP request header parser. A driver feeds byte
// requests from a queue, a predictor computes each result, a monitor compares.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;

  typedef enum logic [3:0] {
    PH_METHOD = 4'd0, PH_PATH = 4'd1, PH_VERSION = 4'd2, PH_LINE_REST = 4'd3,
    PH_NAME = 4'd4, PH_VALUE_LEAD = 4'd5, PH_VALUE = 4'd6, PH_DONE = 4'd8
  } phase_t;

  localparam int WatchdogLimit = 5000;
  localparam int HoldCycles = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hrhp_in_if  in_ch ();
  hrhp_out_if out_ch ();

  http_request_header_parser_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Parser state mirror.
  phase_t      ph;
  int unsigned mpos, mcand, pcnt, vbit, nflags, vcnt, hlen, clen, cmatch, pmatch;
  bit          prev_cr, perr;

  hrhp_pkg::in_item_t  byte_queue[$];
  hrhp_pkg::out_item_t parse_results[$];
  int        failures = 0;
  int        sent_items = 0;
  bit        stim_done = 0;
  bit        hold_req = 0;
  int        hold_cnt = 0;
  bit        no_idle = 0;
  bit        in_taken = 0;

  function automatic string method_text(int m);
    case (m)
      0: return "GET";
      1: return "POST";
      2: return "PUT";
      3: return "DELETE";
      default: return "OPTIONS";
    endcase
  endfunction

  function automatic logic [7:0] lc(logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  task automatic clear_parser();
    ph = PH_METHOD; mpos = 0; mcand = 5'h1f; pcnt = 0; vbit = 0; nflags = 0;
    vcnt = 0; prev_cr = 0; perr = 0; hlen = 0; clen = 0; cmatch = 0; pmatch = 0;
  endtask

  task automatic new_line();
    ph = PH_NAME; mpos = 0; nflags = 3; vcnt = 0;
  endtask

  task automatic value_char(logic [7:0] b, bit crb, inout logic [1:0] cls,
                            inout logic [1:0] act);
    int unsigned len;
    string ka, cl;
    ka = "keep-alive";
    cl = "close";
    ph = PH_VALUE;
    if (b == hrhp_pkg::CH_LF) begin
      len = vcnt;
      if (crb && len > 0) len--;
      if (nflags == 1) begin
        if (len < hrhp_pkg::HostBytes) begin
          hlen = len; act = hrhp_pkg::ACT_COMMIT;
        end else act = hrhp_pkg::ACT_DISCARD;
      end else if (nflags == 2) begin
        if (len < hrhp_pkg::ConnBytes) begin
          clen = len;
          cmatch = (((pmatch & 1) && len == 10) ? 1 : 0) | (((pmatch & 2) && len == 5) ? 2 : 0);
          act = hrhp_pkg::ACT_COMMIT;
        end else act = hrhp_pkg::ACT_DISCARD;
      end
      new_line();
      return;
    end
    cls = (nflags == 1) ? hrhp_pkg::CLS_HOST :
          (nflags == 2) ? hrhp_pkg::CLS_CONN : hrhp_pkg::CLS_OTHER;
    if (nflags == 2) begin
      if (crb) pmatch = 0;
      if (b != hrhp_pkg::CH_CR) begin
        if (!(vcnt < 10 && lc(b) == ka[vcnt])) pmatch &= ~1;
        if (!(vcnt < 5 && lc(b) == cl[vcnt])) pmatch &= ~2;
      end
    end
    if (vcnt < 65535) vcnt++;
  endtask

  task automatic predict_byte(hrhp_pkg::in_item_t it);
    hrhp_pkg::out_item_t r;
    logic [7:0]  b;
    logic [1:0]  cls, act;
    bit          crb, found;
    int unsigned nxt, p, f, code;
    string       mt, vt, ht, ct;
    b = it.data_byte; cls = hrhp_pkg::CLS_OTHER; act = hrhp_pkg::ACT_NONE; code = 0;
    vt = "HTTP/1."; ht = "host"; ct = "connection";
    if (it.frame_start) clear_parser();
    crb = prev_cr;
    case (ph)
      PH_METHOD: begin
        nxt = 0; found = 0;
        for (int i = 0; i < 5; i++) begin
          mt = method_text(i);
          if (!found && mcand[i]) begin
            if (mpos == mt.len() && b == hrhp_pkg::CH_SP) begin
              mcand = 1 << i; found = 1;
            end else if (mpos < mt.len() && b == mt[mpos]) nxt |= 1 << i;
          end
        end
        if (found) begin
          ph = PH_PATH; mpos = 0;
        end else begin
          mcand = nxt;
          if (nxt == 0) begin
            ph = PH_DONE; perr = 1;
          end else mpos++;
        end
      end
      PH_PATH: begin
        if (b == hrhp_pkg::CH_SP) begin
          if (pcnt >= hrhp_pkg::PathBytes) begin
            ph = PH_DONE; perr = 1;
          end else begin
            ph = PH_VERSION; mpos = 0;
          end
        end else if (b == hrhp_pkg::CH_CR || b == hrhp_pkg::CH_LF) begin
          ph = PH_DONE; perr = 1;
        end else begin
          cls = hrhp_pkg::CLS_PATH;
          if (pcnt < 65535) pcnt++;
        end
      end
      PH_VERSION: begin
        p = mpos & 7;
        if (p < 7) begin
          if (b != vt[p]) begin
            ph = PH_DONE; perr = 1;
          end else mpos = p + 1;
        end else if (b == "0" || b == "1") begin
          vbit = {31'd0, b[0]}; ph = PH_LINE_REST;
        end else begin
          ph = PH_DONE; perr = 1;
        end
      end
      PH_LINE_REST: if (b == hrhp_pkg::CH_LF) new_line();
      PH_NAME: begin
        if (b == hrhp_pkg::CH_LF) begin
          if (mpos == 0 || (mpos == 1 && crb)) ph = PH_DONE;
          else new_line();
        end else if (b == hrhp_pkg::CH_COLON) begin
          f = 0;
          if (mpos == 4 && (nflags & 1)) f = 1;
          else if (mpos == 10 && (nflags & 2)) f = 2;
          nflags = f; ph = PH_VALUE_LEAD; vcnt = 0; pmatch = 3;
        end else begin
          f = nflags;
          if (!(mpos < 4 && lc(b) == ht[mpos])) f &= ~1;
          if (!(mpos < 10 && lc(b) == ct[mpos])) f &= ~2;
          nflags = f;
          if (mpos < 511) mpos++;
        end
      end
      PH_VALUE_LEAD:
        if (b != hrhp_pkg::CH_SP && b != hrhp_pkg::CH_TAB) value_char(b, crb, cls, act);
      PH_VALUE: value_char(b, crb, cls, act);
      default: ;
    endcase
    if (ph != PH_DONE) prev_cr = (b == hrhp_pkg::CH_CR);
    if (it.frame_end && ph != PH_DONE) begin
      if (ph <= PH_LINE_REST) perr = 1;
      else if ((ph == PH_VALUE_LEAD || ph == PH_VALUE) && nflags != 0)
        act = hrhp_pkg::ACT_DISCARD;
      ph = PH_DONE;
    end
    for (int i = 4; i >= 0; i--) if (mcand[i]) code = i;
    r.out_byte = b; r.byte_class = cls; r.value_action = act;
    r.done_res = (ph == PH_DONE); r.parse_error = perr; r.method_code = 3'(code);
    r.version_minor = vbit[0];
    r.conn_persist = vbit[0] ? !cmatch[1] : cmatch[0];
    r.path_length = 8'(pcnt > 255 ? 255 : pcnt);
    r.host_length = 8'(hlen > 255 ? 255 : hlen);
    r.connection_length = 6'(clen > 63 ? 63 : clen);
    parse_results.push_back(r);
  endtask

  // Driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else if (!in_ch.valid || in_taken) begin
      if (byte_queue.size() > 0 && (no_idle || $urandom_range(99) >= 17)) begin
        in_ch.data  <= byte_queue[0];
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        predict_byte(in_ch.data);
        void'(byte_queue.pop_front());
      end
    end
  end

  // Sink side readiness; a requested hold-off is counted here.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= HoldCycles;
    end else begin
      out_ch.ready <= no_idle || $urandom_range(99) >= 17;
    end
  end

  // Monitor
  always @(posedge clk) begin
    hrhp_pkg::out_item_t e, a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (parse_results.size() == 0) begin
        $error("result with no request pending: %h", a);
        failures++;
      end else begin
        e = parse_results.pop_front();
        if (a.out_byte != e.out_byte) begin
          $error("out_byte exp %h got %h", e.out_byte, a.out_byte); failures++;
        end
        if (a.byte_class != e.byte_class) begin
          $error("byte_class exp %0d got %0d", e.byte_class, a.byte_class); failures++;
        end
        if (a.value_action != e.value_action) begin
          $error("value_action exp %0d got %0d", e.value_action, a.value_action); failures++;
        end
        if (a.done_res != e.done_res) begin
          $error("done_res exp %0d got %0d", e.done_res, a.done_res); failures++;
        end
        if (a.parse_error != e.parse_error) begin
          $error("parse_error exp %0d got %0d", e.parse_error, a.parse_error); failures++;
        end
        if (a.method_code != e.method_code) begin
          $error("method_code exp %0d got %0d", e.method_code, a.method_code); failures++;
        end
        if (a.version_minor != e.version_minor) begin
          $error("version_minor exp %0d got %0d", e.version_minor, a.version_minor);
          failures++;
        end
        if (a.conn_persist != e.conn_persist) begin
          $error("conn_persist exp %0d got %0d", e.conn_persist, a.conn_persist); failures++;
        end
        if (a.path_length != e.path_length) begin
          $error("path_length exp %0d got %0d", e.path_length, a.path_length); failures++;
        end
        if (a.host_length != e.host_length) begin
          $error("host_length exp %0d got %0d", e.host_length, a.host_length); failures++;
        end
        if (a.connection_length != e.connection_length) begin
          $error("connection_length exp %0d got %0d", e.connection_length,
                 a.connection_length);
          failures++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted request on either side and no hold-off running.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_cnt != 0)
      quiet_cycles <= 0;
    else if (rst_n && !stim_done)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_item(hrhp_pkg::in_item_t it);
    byte_queue.push_back(it);
    sent_items++;
  endtask

  task automatic push_text(string s, bit first, bit last);
    hrhp_pkg::in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.data_byte = s[i];
      it.frame_start = first && (i == 0);
      it.frame_end = last && (i == s.len() - 1);
      push_item(it);
    end
  endtask

  function automatic string case_mix(string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++)
      if ($urandom_range(1)) r[i] = (r[i] >= "a" && r[i] <= "z") ? r[i] - 32 : r[i];
    return r;
  endfunction

  function automatic string rand_text(int n);
    string r;
    r = "";
    for (int i = 0; i < n; i++) r = {r, string'(byte'($urandom_range(33, 126)))};
    return r;
  endfunction

  // One random request, mostly well formed.
  task automatic push_request();
    string s, eol, v, lead, sep;
    int k;
    s = {method_text($urandom_range(4)), " /", rand_text($urandom_range(0, 12)),
         $urandom_range(1) ? " HTTP/1.1" : " HTTP/1.0"};
    if ($urandom_range(9) == 0) s[$urandom_range(s.len() - 1)] = $urandom_range(255);
    k = $urandom_range(0, 3);
    for (int h = 0; h < k; h++) begin
      if ($urandom_range(3) == 0) eol = "\n";
      else eol = "\r\n";
      if ($urandom_range(1)) lead = " \t";
      else lead = "";
      if ($urandom_range(3)) sep = ":";
      else sep = "";
      case ($urandom_range(4))
        0: v = {case_mix("host"), ":", lead, rand_text($urandom_range(8))};
        1: v = {case_mix("connection"), ": ", case_mix("keep-alive")};
        2: v = {case_mix("connection"), ":", case_mix("close")};
        3: v = {case_mix("connection"), ":", rand_text($urandom_range(6))};
        default: v = {rand_text($urandom_range(1, 6)), sep, "x"};
      endcase
      s = {s, eol, v};
    end
    s = {s, "\r\n"};
    if ($urandom_range(4)) s = {s, "\r\n"};
    if ($urandom_range(6) == 0) s = {s, rand_text(2)};
    push_text(s, 1, $urandom_range(5) == 0);
  endtask

  task automatic wait_drained();
    while (byte_queue.size() > 0 || parse_results.size() > 0) @(posedge clk);
  endtask

  initial begin
    string big;
    hrhp_pkg::in_item_t it;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed requests
    push_text("GET / HTTP/1.1\r\nHost: a.b\r\nConnection: Close\r\n\r\n", 1, 0);
    push_text("OPTIONS * HTTP/1.0\nconnection:\tkeep-alive\n\n", 1, 0);
    push_text("DELETE /x HTTP/1.2\r\n", 1, 0);
    push_text("POSTX", 1, 0);
    push_text("PUT /a\rb HTTP/1.1\r\n", 1, 0);
    push_text("GET /p HTTP/1.1\r\nHost: a\r\nHost: bc\r\nnoco\r\nHOST:x\rx\r\n", 1, 1);
    push_text("GET /p HTTP/1", 1, 1);
    it.data_byte = 8'h00; it.frame_start = 1; it.frame_end = 1;
    push_item(it);
    it.data_byte = 8'hff; it.frame_start = 0; it.frame_end = 0;
    push_item(it);
    big = "";
    for (int i = 0; i < 256; i++) big = {big, "a"};
    push_text({"GET /", big, " HTTP/1.1\r\n"}, 1, 0);
    push_text({"GET / HTTP/1.1\r\nHost:", big, "\r\nConnection:", big.substr(0, 63),
               "\r\n\r\n"}, 1, 0);
    push_text({"GET / HTTP/1.0\r\nHost:", big.substr(0, 254), "\r\n\r\n"}, 1, 0);
    wait_drained();

    // Output hold-off: input keeps offering until the block stalls.
    repeat (5) push_request();
    hold_req = 1;
    wait (hold_cnt != 0);
    hold_req = 0;
    wait (hold_cnt == 0);
    wait_drained();

    no_idle = 1;
    repeat (3) push_request();
    wait_drained();
    no_idle = 0;

    while (sent_items < 1500) begin
      if ($urandom_range(9) == 0) begin
        it.data_byte = 8'($urandom);
        it.frame_start = 1'($urandom);
        it.frame_end = 1'($urandom);
        push_item(it);
      end else push_request();
      if (byte_queue.size() > 400) wait_drained();
    end
    wait_drained();
    stim_done = 1;
    repeat (20) @(posedge clk);
    if (failures == 0 && parse_results.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
